FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while in reset.
`define SBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define SBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/sba_pkg.sv
`timescale 1ns / 1ps
package sba_pkg;

  localparam int SIZE_W  = 25;
  localparam int BA_W    = 17;
  localparam int OA_W    = 13;
  localparam int STAT_W  = 2;
  localparam int BIDX_W  = 3;
  localparam int SLOTI_W = 2;
  localparam int CAP_RST = 262144;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] ST_EXIST = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FRAME = 2'd3;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } sba_mem_req_t;

endpackage

FILE: hw/rtl/sba_rem.sv
`timescale 1ns / 1ps
module sba_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sba_pkg::SIZE_W:0]     dividend,
  input  logic [sba_pkg::BA_W-1:0]     divisor,
  output logic                         done,
  output logic [sba_pkg::BA_W-1:0]     rem
);
  import sba_pkg::*;

  localparam int VW = SIZE_W + 1;

  logic              run_r;
  logic [4:0]        cnt_r;
  logic [VW-1:0]     v_r;
  logic [BA_W-1:0]   a_r;
  logic [BA_W:0]     r_r;
  logic              done_r;
  logic [BA_W:0]     shifted;
  logic [BA_W:0]     r_nxt;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {r_r[BA_W-1:0], v_r[VW-1]};
    if (shifted >= {1'b0, a_r}) begin
      r_nxt = shifted - {1'b0, a_r};
    end else begin
      r_nxt = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        v_r   <= dividend;
        a_r   <= divisor;
        r_r   <= '0;
      end else if (run_r) begin
        r_r   <= r_nxt;
        v_r   <= {v_r[VW-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(VW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r[BA_W-1:0];

endmodule

FILE: hw/rtl/sba_mem.sv
`timescale 1ns / 1ps
module sba_mem #(
  parameter int AW     = 6,
  parameter int SLOT_W = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sba_pkg::sba_mem_req_t         req,
  input  logic [AW-1:0]                 addr,
  input  logic [SLOT_W-1:0]             clr_slot,
  input  logic [sba_pkg::SIZE_W-1:0]    wr_cap,
  input  logic [sba_pkg::SIZE_W-1:0]    wr_fill,
  output logic [sba_pkg::SIZE_W-1:0]    rd_cap,
  output logic [sba_pkg::SIZE_W-1:0]    rd_fill
);
  import sba_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic [2*SIZE_W-1:0] mem [DEPTH];
  logic [2*SIZE_W-1:0] rd_data_r;
  logic                rd_zero_r;
  logic [DEPTH-1:0]    zero_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= {wr_cap, wr_fill};
    end
    if (req.rd) begin
      rd_data_r <= mem[addr];
      rd_zero_r <= zero_r[addr];
    end
  end

  // per-entry "fill is zero" marks: a frame restart sets a whole slot at once
  for (genvar e = 0; e < DEPTH; e++) begin : g_zero
    localparam logic [AW-1:0] EA = AW'(e);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        zero_r[e] <= 1'b0;
      end else if (req.clr && EA[AW-1 -: SLOT_W] == clr_slot) begin
        zero_r[e] <= 1'b1;
      end else if (req.wr && addr == EA) begin
        zero_r[e] <= 1'b0;
      end
    end
  end

  assign rd_cap  = rd_data_r[2*SIZE_W-1:SIZE_W];
  assign rd_fill = rd_zero_r ? '0 : rd_data_r[SIZE_W-1:0];

endmodule

FILE: hw/rtl/staging_block_suballocator.sv
`timescale 1ns / 1ps
// Staging buffer suballocator. A begin-frame command (start with busy low)
// gives its status-3 result on out_strobe in the next cycle and leaves busy
// low. An allocate command holds busy while it scans the list one buffer at
// a time: each buffer costs one memory read plus two passes through the
// shared bit-serial remainder unit, and opening a new buffer costs one more
// pass. Results appear for one cycle on out_strobe and must be taken then;
// there is no backpressure.
module staging_block_suballocator #(
  parameter int FRAME_SLOTS = 4,
  parameter int MAX_BUFFERS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [sba_pkg::SLOTI_W-1:0]   in_frame_slot,
  input  logic                          in_first_use,
  input  logic                          in_direction,
  input  logic [sba_pkg::SIZE_W-1:0]    in_required_size,
  input  logic [sba_pkg::BA_W-1:0]      in_block_align,
  input  logic [sba_pkg::OA_W-1:0]      in_offset_align,
  input  logic [sba_pkg::SIZE_W-1:0]    in_min_size,
  output logic                          out_strobe,
  output logic [sba_pkg::STAT_W-1:0]    out_status,
  output logic [sba_pkg::BIDX_W-1:0]    out_buffer_index,
  output logic [sba_pkg::SIZE_W-1:0]    out_offset,
  output logic [sba_pkg::SIZE_W-1:0]    out_granted_size,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sba_pkg::*;

  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int IDX_W  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
  localparam int AW     = SLOT_W + 1 + IDX_W;
  localparam int NLIST  = 2 ** (SLOT_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_LAT, S_UP, S_DN, S_EVAL, S_NEW, S_WR
  } state_t;

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOTI_W-1:0] s);
    logic [4:0] t;
    t = {3'b0, s};
    for (int k = 0; k < 3; k++) begin
      if (t >= 5'(FRAME_SLOTS)) t = t - 5'(FRAME_SLOTS);
    end
    return SLOT_W'(t);
  endfunction

  state_t              state_r;
  logic [SIZE_W-1:0]   capacity_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]    count_r [NLIST];
  logic                dir_r;
  logic [SIZE_W-1:0]   req_r;
  logic [SIZE_W-1:0]   min_r;
  logic [BA_W-1:0]     ba_r;
  logic [OA_W-1:0]     oa_r;
  logic [CNT_W-1:0]    n_r;
  logic [IDX_W-1:0]    i_r;
  logic [SIZE_W-1:0]   fill_r;
  logic [SIZE_W-1:0]   cap_r;
  logic [SIZE_W-1:0]   off_r;
  logic [SIZE_W-1:0]   space_r;
  logic                new_r;
  logic                have_best_r;
  logic [IDX_W-1:0]    best_r;
  logic [SIZE_W-1:0]   best_off_r;
  logic [SIZE_W-1:0]   best_space_r;
  logic [IDX_W-1:0]    pick_r;
  logic [SIZE_W-1:0]   best_cap_r;

  logic                out_strobe_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [BIDX_W-1:0]   out_index_r;
  logic [SIZE_W-1:0]   out_offset_r;
  logic [SIZE_W-1:0]   out_grant_r;

  logic                accept;
  logic                cfg_wr;
  logic [SLOT_W:0]     list_sel;
  sba_mem_req_t        mreq;
  logic [AW-1:0]       maddr;
  logic [SIZE_W-1:0]   m_cap;
  logic [SIZE_W-1:0]   m_fill;
  logic [SIZE_W-1:0]   grant;
  logic                rem_start;
  logic [SIZE_W:0]     rem_v;
  logic [BA_W-1:0]     rem_a;
  logic                rem_done;
  logic [BA_W-1:0]     rem;
  logic [SIZE_W:0]     off_raw;
  logic [SIZE_W-1:0]   off_sat;
  logic [SIZE_W-1:0]   space_nxt;
  logic [SLOT_W-1:0]   new_slot;
  logic [CNT_W-1:0]    cnt_sel;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = {{(32 - SIZE_W){1'b0}}, capacity_r};
  assign list_sel = {slot_r, dir_r};
  assign new_slot = wrap_slot(in_frame_slot);
  assign cnt_sel  = count_r[{slot_r, in_direction}];
  assign grant    = (space_r < req_r) ? space_r : req_r;

  // round the fill up: off = fill + (oa - r) unless already aligned, then clamp
  always_comb begin
    if (rem == '0) begin
      off_raw = {1'b0, fill_r};
    end else begin
      off_raw = {1'b0, fill_r} + (SIZE_W + 1)'(oa_r) - (SIZE_W + 1)'(rem);
    end
    off_sat   = (off_raw > {1'b0, cap_r}) ? cap_r : off_raw[SIZE_W-1:0];
    space_nxt = (cap_r - off_r) - SIZE_W'(rem);
  end

  always_comb begin
    rem_start = 1'b0;
    rem_v     = {1'b0, m_fill};
    rem_a     = BA_W'(oa_r);
    unique case (state_r)
      S_LAT: begin
        rem_start = 1'b1;
      end
      S_UP: begin
        rem_start = rem_done;
        rem_v     = {1'b0, cap_r - off_sat};
        rem_a     = ba_r;
      end
      S_NEW: begin
        rem_start = 1'b1;
        rem_v     = {1'b0, capacity_r};
        rem_a     = ba_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mreq.rd  = (state_r == S_RD);
    mreq.wr  = (state_r == S_WR);
    mreq.clr = accept && (in_action == ACT_BEGIN) && in_first_use;
    maddr    = (state_r == S_WR) ? {slot_r, dir_r, pick_r} : {slot_r, dir_r, i_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= SIZE_W'(CAP_RST);
    end else if (cfg_wr) begin
      capacity_r <= pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_r       <= '0;
      out_strobe_r <= 1'b0;
      for (int k = 0; k < NLIST; k++) count_r[k] <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_action == ACT_BEGIN) begin
              slot_r       <= new_slot;
              out_strobe_r <= 1'b1;
              out_status_r <= ST_FRAME;
              out_index_r  <= '0;
              out_offset_r <= '0;
              out_grant_r  <= '0;
            end else begin
              dir_r       <= in_direction;
              req_r       <= in_required_size;
              min_r       <= in_min_size;
              ba_r        <= (in_block_align == '0) ? BA_W'(1) : in_block_align;
              oa_r        <= (in_offset_align == '0) ? OA_W'(1) : in_offset_align;
              n_r         <= (cnt_sel > CNT_W'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS)
                                                             : cnt_sel;
              i_r         <= '0;
              have_best_r <= 1'b0;
              new_r       <= 1'b0;
              state_r     <= (cnt_sel == '0) ? S_NEW : S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_LAT;
        end
        S_LAT: begin
          fill_r  <= m_fill;
          cap_r   <= m_cap;
          state_r <= S_UP;
        end
        S_UP: begin
          if (rem_done) begin
            off_r   <= off_sat;
            state_r <= S_DN;
          end
        end
        S_DN: begin
          if (rem_done) begin
            space_r <= space_nxt;
            state_r <= new_r ? S_WR : S_EVAL;
          end
        end
        S_EVAL: begin
          if (space_r >= req_r) begin
            pick_r  <= i_r;
            state_r <= S_WR;
          end else begin
            if (!have_best_r || space_r > best_space_r) begin
              have_best_r  <= 1'b1;
              best_r       <= i_r;
              best_off_r   <= off_r;
              best_space_r <= space_r;
              best_cap_r   <= cap_r;
            end
            if (CNT_W'(i_r) + CNT_W'(1) == n_r) begin
              // scan over: take the largest if big enough, else open or fail
              if (have_best_r && space_r <= best_space_r && best_space_r >= min_r) begin
                pick_r  <= best_r;
                off_r   <= best_off_r;
                space_r <= best_space_r;
                cap_r   <= best_cap_r;
                state_r <= S_WR;
              end else if ((!have_best_r || space_r > best_space_r) && space_r >= min_r) begin
                pick_r  <= i_r;
                state_r <= S_WR;
              end else if (n_r >= CNT_W'(MAX_BUFFERS)) begin
                out_strobe_r <= 1'b1;
                out_status_r <= ST_FULL;
                out_index_r  <= '0;
                out_offset_r <= '0;
                out_grant_r  <= '0;
                state_r      <= S_IDLE;
              end else begin
                state_r <= S_NEW;
              end
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= S_RD;
            end
          end
        end
        S_NEW: begin
          new_r   <= 1'b1;
          pick_r  <= IDX_W'(n_r);
          cap_r   <= capacity_r;
          off_r   <= '0;
          state_r <= S_DN;
        end
        S_WR: begin
          if (new_r) count_r[list_sel] <= n_r + CNT_W'(1);
          out_strobe_r <= 1'b1;
          out_status_r <= new_r ? ST_NEW : ST_EXIST;
          out_index_r  <= BIDX_W'(pick_r);
          out_offset_r <= off_r;
          out_grant_r  <= grant;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  sba_mem #(
    .AW     (AW),
    .SLOT_W (SLOT_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mreq),
    .addr     (maddr),
    .clr_slot (new_slot),
    .wr_cap   (cap_r),
    .wr_fill  (off_r + grant),
    .rd_cap   (m_cap),
    .rd_fill  (m_fill)
  );

  sba_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_v),
    .divisor  (rem_a),
    .done     (rem_done),
    .rem      (rem)
  );

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_buffer_index = out_index_r;
  assign out_offset       = out_offset_r;
  assign out_granted_size = out_grant_r;

endmodule

FILE: hw/rtl/sba_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_action,
  input logic                         out_strobe,
  input logic [sba_pkg::STAT_W-1:0]   out_status,
  input logic [sba_pkg::BIDX_W-1:0]   out_buffer_index,
  input logic [sba_pkg::SIZE_W-1:0]   out_offset,
  input logic [sba_pkg::SIZE_W-1:0]   out_granted_size
);
  import sba_pkg::*;

  `SBA_ASSERT(a_frame_zero, out_strobe && out_status == ST_FRAME |-> out_buffer_index == '0 && out_offset == '0 && out_granted_size == '0, "frame beat with nonzero fields")
  `SBA_ASSERT(a_full_zero, out_strobe && out_status == ST_FULL |-> out_buffer_index == '0 && out_offset == '0 && out_granted_size == '0, "full beat with nonzero fields")
  `SBA_ASSERT(a_alloc_busy, start && !busy && in_action == ACT_ALLOC |=> busy && !out_strobe, "allocate did not hold busy")
  `SBA_ASSERT(a_begin_beat, start && !busy && in_action == ACT_BEGIN |=> out_strobe && out_status == ST_FRAME, "begin frame beat missing")

endmodule

bind staging_block_suballocator sba_checker u_sba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_buffer_index (out_buffer_index),
  .out_offset       (out_offset),
  .out_granted_size (out_granted_size)
);
